// ===== design/two_stream_timestamp_pairer_defines.svh =====
// ----------------------------------------------------------------------------
// two_stream_timestamp_pairer_defines
// assertion macros used by the timestamp pairer datapath
// ----------------------------------------------------------------------------
`ifndef TWO_STREAM_TIMESTAMP_PAIRER_DEFINES_SVH
`define TWO_STREAM_TIMESTAMP_PAIRER_DEFINES_SVH

`ifndef ASSERT_OFF

// checked property, masked while reset is asserted
`define TSP_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked property, also watched during reset
`define TSP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define TSP_ASSERT(lbl, clk, rst_n, prop, msg)
`define TSP_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== design/tsp_pkg.sv =====
// ----------------------------------------------------------------------------
// tsp_pkg
// types and constants shared by the timestamp pairer modules
// ----------------------------------------------------------------------------
package tsp_pkg;

	// fixed field widths
	localparam int STAMP_W    = 64;
	localparam int TAG_IO_W   = 16;
	localparam int KIND_W     = 3;
	localparam int WINDOW_W   = 32;
	localparam int FILL_W     = 5;
	localparam int RES_CNT_W  = 6;
	localparam int IN_DATA_W  = 80;
	localparam int OUT_DATA_W = 96;
	localparam int CFG_IDX_W  = 2;

	// results per input transaction are capped
	localparam logic [RES_CNT_W-1:0] MAX_RESULTS = 6'd61;

	// register reset values
	localparam logic [WINDOW_W-1:0] WINDOW_RST = 32'd500;
	localparam logic [FILL_W-1:0]   FILL_RST   = 5'd2;

	// frame source codes
	localparam logic SRC_A = 1'b0;
	localparam logic SRC_B = 1'b1;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MATCH_WINDOW = 2'd0,
		REG_MIN_FILL     = 2'd1
	} cfg_reg_t;

	// result kinds
	typedef enum logic [KIND_W-1:0] {
		EV_PAIR   = 3'd0,
		EV_LONE_A = 3'd1,
		EV_LONE_B = 3'd2,
		EV_OVF_A  = 3'd3,
		EV_OVF_B  = 3'd4,
		EV_MIS_A  = 3'd5,
		EV_MIS_B  = 3'd6
	} ev_kind_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic ovf_emit;
		logic push;
		logic calc;
		logic cmp_emit;
		logic lone_emit;
	} tsp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic full;
		logic drain_go;
		logic loop_more;
		logic lone_go;
		logic out_free;
	} tsp_sts_t;

endpackage

// ===== design/tsp_ram.sv =====
// ----------------------------------------------------------------------------
// tsp_ram
// simple dual-port ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module tsp_ram #(
	parameter int WIDTH = 80,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

// ===== design/tsp_ctrl.sv =====
// ----------------------------------------------------------------------------
// tsp_ctrl
// sequencer for push, overflow drop and head-to-head drain
// ----------------------------------------------------------------------------
module tsp_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  tsp_pkg::tsp_sts_t  sts,
	output tsp_pkg::tsp_cmd_t  cmd
);

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_OVF  = 8'b0000_0010,
		S_PUSH = 8'b0000_0100,
		S_CHK  = 8'b0000_1000,
		S_CALC = 8'b0001_0000,
		S_EMIT = 8'b0010_0000,
		S_RD   = 8'b0100_0000,
		S_LONE = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign s_tready = (state_q == S_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					state_d    = sts.full ? S_OVF : S_PUSH;
				end
			end
			S_OVF: begin
				if (sts.out_free) begin
					cmd.ovf_emit = 1'b1;
					state_d      = S_PUSH;
				end
			end
			S_PUSH: begin
				cmd.push = 1'b1;
				state_d  = S_CHK;
			end
			S_CHK: begin
				state_d = sts.drain_go ? S_CALC : S_IDLE;
			end
			S_CALC: begin
				cmd.calc = 1'b1;
				state_d  = S_EMIT;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.cmp_emit = 1'b1;
					state_d      = S_RD;
				end
			end
			S_RD: begin
				// heads moved, ram output refreshes during this cycle
				if (sts.loop_more) begin
					state_d = S_CALC;
				end else if (sts.lone_go) begin
					state_d = S_LONE;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_LONE: begin
				if (sts.out_free) begin
					cmd.lone_emit = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== design/tsp_dp.sv =====
// ----------------------------------------------------------------------------
// tsp_dp
// frame fifos, head comparison, config registers and result register
// ----------------------------------------------------------------------------
`include "two_stream_timestamp_pairer_defines.svh"

module tsp_dp #(
	parameter int QUEUE_DEPTH = 32,
	parameter int TAG_BITS    = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic [tsp_pkg::IN_DATA_W-1:0]        s_tdata,
	input  logic                                 s_tuser,
	input  logic                                 cfg_valid,
	input  logic [tsp_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [tsp_pkg::WINDOW_W-1:0]         cfg_data,
	input  tsp_pkg::tsp_cmd_t                    cmd,
	output tsp_pkg::tsp_sts_t                    sts,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [tsp_pkg::OUT_DATA_W-1:0]       m_tdata,
	output logic [tsp_pkg::KIND_W-1:0]           m_tuser,
	output logic                                 m_tlast
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int SUM_W = CNT_W + 1;
	localparam int ENT_W = tsp_pkg::STAMP_W + TAG_BITS;
	localparam int CMP_W = (CNT_W > tsp_pkg::FILL_W) ? CNT_W : tsp_pkg::FILL_W;
	localparam int SW    = tsp_pkg::STAMP_W;
	localparam int TW    = tsp_pkg::TAG_IO_W;
	localparam int NW    = tsp_pkg::RES_CNT_W;

	localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(QUEUE_DEPTH);
	localparam logic [SUM_W-1:0] DEPTH_S  = SUM_W'(QUEUE_DEPTH);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

	// fifo bookkeeping
	logic [CNT_W-1:0] cnt_a_q, cnt_b_q;
	logic [PTR_W-1:0] head_a_q, head_b_q;

	// config registers
	logic [tsp_pkg::WINDOW_W-1:0] window_q;
	logic [tsp_pkg::FILL_W-1:0]   fill_q;

	// latched input transaction
	logic                src_q;
	logic [SW-1:0]       stamp_q;
	logic [TAG_BITS-1:0] tag_q;

	// drain progress
	logic [NW-1:0] n_q;
	logic          matched_q;

	// comparison stage
	logic [SW-1:0] diff_ab_s1, diff_ba_s1;
	logic          lt_s1;

	// ram read data
	logic [ENT_W-1:0]    ent_a, ent_b;
	logic [SW-1:0]       sa, sb;
	logic [TAG_BITS-1:0] tga, tgb;

	assign sa  = ent_a[SW-1:0];
	assign sb  = ent_b[SW-1:0];
	assign tga = ent_a[ENT_W-1:SW];
	assign tgb = ent_b[ENT_W-1:SW];

	// push address: tail of the target fifo
	logic [CNT_W-1:0] cnt_t;
	logic [PTR_W-1:0] head_t;
	logic [SUM_W-1:0] tail_sum;
	logic [PTR_W-1:0] tail;
	logic             push_a, push_b;

	assign cnt_t    = (src_q == tsp_pkg::SRC_B) ? cnt_b_q : cnt_a_q;
	assign head_t   = (src_q == tsp_pkg::SRC_B) ? head_b_q : head_a_q;
	assign tail_sum = SUM_W'(head_t) + SUM_W'(cnt_t);
	assign tail     = (tail_sum >= DEPTH_S) ? PTR_W'(tail_sum - DEPTH_S) : PTR_W'(tail_sum);
	assign push_a   = cmd.push && (src_q == tsp_pkg::SRC_A);
	assign push_b   = cmd.push && (src_q == tsp_pkg::SRC_B);

	tsp_ram #(
		.WIDTH (ENT_W),
		.DEPTH (QUEUE_DEPTH)
	) u_ram_a (
		.clk   (clk),
		.we    (push_a),
		.waddr (tail),
		.wdata ({tag_q, stamp_q}),
		.raddr (head_a_q),
		.rdata (ent_a)
	);

	tsp_ram #(
		.WIDTH (ENT_W),
		.DEPTH (QUEUE_DEPTH)
	) u_ram_b (
		.clk   (clk),
		.we    (push_b),
		.waddr (tail),
		.wdata ({tag_q, stamp_q}),
		.raddr (head_b_q),
		.rdata (ent_b)
	);

	// window check on the registered differences
	logic in_win;
	logic pop_a_cmp, pop_b_cmp;
	logic lone_is_a;
	logic pop_a, pop_b;

	assign in_win    = (lt_s1 ? diff_ba_s1 : diff_ab_s1) < SW'(window_q);
	assign pop_a_cmp = in_win || lt_s1;
	assign pop_b_cmp = in_win || !lt_s1;
	assign lone_is_a = (cnt_b_q == '0);
	assign pop_a     = (cmd.ovf_emit && (src_q == tsp_pkg::SRC_A)) ||
	                   (cmd.cmp_emit && pop_a_cmp) || (cmd.lone_emit && lone_is_a);
	assign pop_b     = (cmd.ovf_emit && (src_q == tsp_pkg::SRC_B)) ||
	                   (cmd.cmp_emit && pop_b_cmp) || (cmd.lone_emit && !lone_is_a);

	// fill comparisons
	logic [CMP_W-1:0] fill_x;
	logic             a_over, b_over, depth_over;
	logic             a_nz, b_nz, n_room;

	assign fill_x     = CMP_W'(fill_q);
	assign a_over     = CMP_W'(cnt_a_q) > fill_x;
	assign b_over     = CMP_W'(cnt_b_q) > fill_x;
	assign depth_over = CMP_W'(DEPTH_C) > fill_x;
	assign a_nz       = (cnt_a_q != '0);
	assign b_nz       = (cnt_b_q != '0);
	assign n_room     = (n_q < tsp_pkg::MAX_RESULTS);

	// status to the controller
	always_comb begin
		sts           = '0;
		sts.full      = (s_tuser == tsp_pkg::SRC_B) ? (cnt_b_q == DEPTH_C) :
		                (cnt_a_q == DEPTH_C);
		sts.drain_go  = a_over && b_over;
		sts.loop_more = a_nz && b_nz && n_room;
		sts.lone_go   = !matched_q && n_room && (a_nz ^ b_nz);
		sts.out_free  = !m_tvalid || m_tready;
	end

	// last flag for a compare result: does anything follow it
	logic [NW-1:0] n_next;
	logic          a_nz_next, b_nz_next, matched_next, cmp_more;
	logic          ovf_more;

	assign n_next       = n_q + NW'(1);
	assign a_nz_next    = pop_a_cmp ? (cnt_a_q != CNT_ONE) : 1'b1;
	assign b_nz_next    = pop_b_cmp ? (cnt_b_q != CNT_ONE) : 1'b1;
	assign matched_next = matched_q || in_win;
	assign cmp_more     = (n_next < tsp_pkg::MAX_RESULTS) &&
	                      ((a_nz_next && b_nz_next) ||
	                       (!matched_next && (a_nz_next || b_nz_next)));
	// after an overflow the target stays full and the drain always yields a result
	assign ovf_more     = depth_over && ((src_q == tsp_pkg::SRC_B) ? a_over : b_over);

	// result assembly
	tsp_pkg::ev_kind_t kind;
	logic [TW-1:0]     res_tag_a, res_tag_b;
	logic [SW-1:0]     res_stamp;
	logic              res_last;
	logic              emit;

	assign emit = cmd.ovf_emit || cmd.cmp_emit || cmd.lone_emit;

	always_comb begin
		kind      = tsp_pkg::EV_PAIR;
		res_tag_a = '0;
		res_tag_b = '0;
		res_stamp = sa;
		res_last  = 1'b1;
		if (cmd.ovf_emit) begin
			res_last = !ovf_more;
			if (src_q == tsp_pkg::SRC_B) begin
				kind      = tsp_pkg::EV_OVF_B;
				res_tag_b = TW'(tgb);
				res_stamp = sb;
			end else begin
				kind      = tsp_pkg::EV_OVF_A;
				res_tag_a = TW'(tga);
				res_stamp = sa;
			end
		end else if (cmd.cmp_emit) begin
			res_last = !cmp_more;
			if (in_win) begin
				kind      = tsp_pkg::EV_PAIR;
				res_tag_a = TW'(tga);
				res_tag_b = TW'(tgb);
				res_stamp = lt_s1 ? sb : sa;
			end else if (lt_s1) begin
				kind      = tsp_pkg::EV_MIS_A;
				res_tag_a = TW'(tga);
				res_stamp = sa;
			end else begin
				kind      = tsp_pkg::EV_MIS_B;
				res_tag_b = TW'(tgb);
				res_stamp = sb;
			end
		end else if (lone_is_a) begin
			kind      = tsp_pkg::EV_LONE_A;
			res_tag_a = TW'(tga);
			res_stamp = sa;
		end else begin
			kind      = tsp_pkg::EV_LONE_B;
			res_tag_b = TW'(tgb);
			res_stamp = sb;
		end
	end

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= tsp_pkg::WINDOW_RST;
			fill_q   <= tsp_pkg::FILL_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				tsp_pkg::REG_MATCH_WINDOW: window_q <= cfg_data;
				tsp_pkg::REG_MIN_FILL:     fill_q   <= cfg_data[tsp_pkg::FILL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// fifo counts and heads
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_a_q  <= '0;
			cnt_b_q  <= '0;
			head_a_q <= '0;
			head_b_q <= '0;
		end else begin
			if (push_a) begin
				cnt_a_q <= cnt_a_q + CNT_ONE;
			end else if (pop_a) begin
				cnt_a_q  <= cnt_a_q - CNT_ONE;
				head_a_q <= (head_a_q == PTR_LAST) ? '0 : head_a_q + PTR_W'(1);
			end
			if (push_b) begin
				cnt_b_q <= cnt_b_q + CNT_ONE;
			end else if (pop_b) begin
				cnt_b_q  <= cnt_b_q - CNT_ONE;
				head_b_q <= (head_b_q == PTR_LAST) ? '0 : head_b_q + PTR_W'(1);
			end
		end
	end

	// result count and match flag for the current transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q       <= '0;
			matched_q <= 1'b0;
		end else if (cmd.accept) begin
			n_q       <= '0;
			matched_q <= 1'b0;
		end else begin
			if (emit) begin
				n_q <= n_next;
			end
			if (cmd.cmp_emit && in_win) begin
				matched_q <= 1'b1;
			end
		end
	end

	// input latch
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			src_q   <= s_tuser;
			stamp_q <= s_tdata[SW-1:0];
			tag_q   <= TAG_BITS'(s_tdata[tsp_pkg::IN_DATA_W-1:SW]);
		end
	end

	// head differences, both directions
	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			diff_ab_s1 <= sa - sb;
			diff_ba_s1 <= sb - sa;
			lt_s1      <= (sa < sb);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (emit) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			m_tdata <= {res_stamp, res_tag_b, res_tag_a};
			m_tuser <= kind;
			m_tlast <= res_last;
		end
	end

	`TSP_ASSERT(a_cnt_bound, clk, arst_n, (cnt_a_q <= DEPTH_C) && (cnt_b_q <= DEPTH_C), "fifo count above depth")
	`TSP_ASSERT(a_res_bound, clk, arst_n, n_q <= tsp_pkg::MAX_RESULTS, "result budget exceeded")
	`TSP_ASSERT(a_emit_free, clk, arst_n, emit |-> sts.out_free, "result written over a waiting result")
	`TSP_ASSERT(a_ovf_pop, clk, arst_n, cmd.ovf_emit |=> (((src_q == tsp_pkg::SRC_B) ? cnt_b_q : cnt_a_q) == (DEPTH_C - CNT_ONE)), "overflow drop did not free one slot")

endmodule

// ===== design/two_stream_timestamp_pairer.sv =====
// ----------------------------------------------------------------------------
// two_stream_timestamp_pairer
// pairs frames from two sensors by capture timestamp
// ----------------------------------------------------------------------------
// Input stream: one transaction per frame arrival; s_tuser selects sensor A
// or B, s_tdata carries the timestamp and the frame tag. Each frame goes
// into its sensor's fifo; a full fifo first drops its oldest frame as an
// overflow result. Once both fifos hold more than min_fill frames the heads
// are compared until one fifo runs empty or the result cap is hit: pairs,
// mismatches and possibly one lone head leave on the output stream, m_tlast
// on the final result of the input transaction. An input may cause no result
// at all. The sequencer takes one input at a time: an overflow drop if
// needed, the push, then per compare result the compare loop (ram read,
// difference register, decision), and at most one lone head. s_tready is
// high only between inputs. Results wait in one output register: a stall on
// m_tready holds the sequencer in place with nothing lost. Reset empties both
// fifos and loads match_window 500 and min_fill 2; no clearing pass is
// needed. Config writes through the cfg channel are always ready and take
// effect on the next cycle.
// ----------------------------------------------------------------------------
module two_stream_timestamp_pairer #(
	parameter int QUEUE_DEPTH = 32,
	parameter int TAG_BITS    = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// input frames
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [tsp_pkg::IN_DATA_W-1:0]        s_tdata,  // stamp[63:0], frame_tag[79:64]
	input  logic                                 s_tuser,  // command (0 sensor A, 1 sensor B)
	// results
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [tsp_pkg::OUT_DATA_W-1:0]       m_tdata,  // tag_a[15:0], tag_b[31:16], out_stamp[95:32]
	output logic [tsp_pkg::KIND_W-1:0]           m_tuser,  // event_kind[2:0]
	output logic                                 m_tlast,
	// register writes
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [tsp_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [tsp_pkg::WINDOW_W-1:0]         cfg_data
);

	tsp_pkg::tsp_cmd_t cmd;
	tsp_pkg::tsp_sts_t sts;

	assign cfg_ready = 1'b1;

	tsp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tsp_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.TAG_BITS    (TAG_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the two-stream timestamp pairer
// ----------------------------------------------------------------------------
// Frames from sensors A and B go in over the input stream. A local model of
// the two frame fifos works out the overflow, pair, mismatch and lone-head
// events for each frame. A monitor compares every output transaction, field
// by field, with the oldest predicted event. The directed tests cover the
// window edges, extreme stamps and tags, overflow and the cap on results per
// frame. The random test then runs mostly sensor streams with jitter, some
// dropped frames and some noise, under several register settings. Both sides
// of the stream idle at random, and a watchdog stops a hung run.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FIFO_DEPTH  = 32;
	localparam int STALL_PCT   = 23;
	localparam int SETTLE_CYC  = 12;
	localparam int HANG_LIMIT  = 2000;
	localparam logic [tsp_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [tsp_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

	// one stored frame
	typedef struct packed {
		logic [tsp_pkg::STAMP_W-1:0]  stamp;
		logic [tsp_pkg::TAG_IO_W-1:0] tag;
	} frame_rec_t;

	// one output event
	typedef struct {
		tsp_pkg::ev_kind_t            kind;
		logic [tsp_pkg::TAG_IO_W-1:0] tag_a;
		logic [tsp_pkg::TAG_IO_W-1:0] tag_b;
		logic [tsp_pkg::STAMP_W-1:0]  stamp;
		logic                         last;
	} sync_event_t;

	logic                             clk;
	logic                             arst_n;
	logic                             s_tvalid;
	logic                             s_tready;
	logic [tsp_pkg::IN_DATA_W-1:0]    s_tdata;   // stamp[63:0], frame_tag[79:64]
	logic                             s_tuser;   // command (0 sensor A, 1 sensor B)
	logic                             m_tvalid;
	logic                             m_tready;
	logic [tsp_pkg::OUT_DATA_W-1:0]   m_tdata;   // tag_a[15:0], tag_b[31:16], out_stamp[95:32]
	logic [tsp_pkg::KIND_W-1:0]       m_tuser;   // event_kind[2:0]
	logic                             m_tlast;
	logic                             cfg_valid;
	logic                             cfg_ready;
	logic [tsp_pkg::CFG_IDX_W-1:0]    cfg_index;
	logic [tsp_pkg::WINDOW_W-1:0]     cfg_data;

	// model state
	frame_rec_t                       frames_a[$];
	frame_rec_t                       frames_b[$];
	sync_event_t                      pending_events[$];
	logic [tsp_pkg::WINDOW_W-1:0]     window_reg;
	logic [tsp_pkg::FILL_W-1:0]       fill_reg;

	// bench control
	bit                               idle_en;
	bit                               stall_en;
	int                               err_count;
	int                               hang_cycles;
	logic [tsp_pkg::STAMP_W-1:0]      stream_ns;

	two_stream_timestamp_pairer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// clock
	always #1 clk = ~clk;

	function automatic sync_event_t make_event(input tsp_pkg::ev_kind_t kind,
			input logic [tsp_pkg::TAG_IO_W-1:0] tag_a,
			input logic [tsp_pkg::TAG_IO_W-1:0] tag_b,
			input logic [tsp_pkg::STAMP_W-1:0] stamp);
		sync_event_t ev;
		ev.kind  = kind;
		ev.tag_a = tag_a;
		ev.tag_b = tag_b;
		ev.stamp = stamp;
		ev.last  = 1'b0;
		return ev;
	endfunction

	// push one frame into the model fifos and queue up the events it causes
	function automatic void pair_arrival(input logic src,
			input logic [tsp_pkg::STAMP_W-1:0] stamp,
			input logic [tsp_pkg::TAG_IO_W-1:0] tag);
		sync_event_t                 batch[$];
		frame_rec_t                  head_a;
		frame_rec_t                  head_b;
		frame_rec_t                  incoming;
		logic [tsp_pkg::STAMP_W-1:0] gap;
		bit                          paired;
		paired         = 1'b0;
		incoming.stamp = stamp;
		incoming.tag   = tag;
		// full fifo loses its oldest frame first
		if (src == tsp_pkg::SRC_B) begin
			if (frames_b.size() >= FIFO_DEPTH) begin
				head_b = frames_b[0];
				frames_b.delete(0);
				batch.insert(batch.size(),
					make_event(tsp_pkg::EV_OVF_B, '0, head_b.tag, head_b.stamp));
			end
			frames_b.insert(frames_b.size(), incoming);
		end else begin
			if (frames_a.size() >= FIFO_DEPTH) begin
				head_a = frames_a[0];
				frames_a.delete(0);
				batch.insert(batch.size(),
					make_event(tsp_pkg::EV_OVF_A, head_a.tag, '0, head_a.stamp));
			end
			frames_a.insert(frames_a.size(), incoming);
		end
		// head comparison until one side runs dry or the result cap is hit
		if (frames_a.size() > int'(fill_reg) && frames_b.size() > int'(fill_reg)) begin
			while (frames_a.size() != 0 && frames_b.size() != 0 &&
					batch.size() < int'(tsp_pkg::MAX_RESULTS)) begin
				head_a = frames_a[0];
				head_b = frames_b[0];
				gap = (head_a.stamp > head_b.stamp) ? head_a.stamp - head_b.stamp :
					head_b.stamp - head_a.stamp;
				if (gap < {32'd0, window_reg}) begin
					paired = 1'b1;
					batch.insert(batch.size(),
						make_event(tsp_pkg::EV_PAIR, head_a.tag, head_b.tag,
						(head_a.stamp > head_b.stamp) ? head_a.stamp : head_b.stamp));
					frames_a.delete(0);
					frames_b.delete(0);
				end else if (head_a.stamp < head_b.stamp) begin
					batch.insert(batch.size(),
						make_event(tsp_pkg::EV_MIS_A, head_a.tag, '0, head_a.stamp));
					frames_a.delete(0);
				end else begin
					batch.insert(batch.size(),
						make_event(tsp_pkg::EV_MIS_B, '0, head_b.tag, head_b.stamp));
					frames_b.delete(0);
				end
			end
			// lone head only when nothing paired
			if (!paired && batch.size() < int'(tsp_pkg::MAX_RESULTS)) begin
				if (frames_b.size() == 0 && frames_a.size() != 0) begin
					head_a = frames_a[0];
					frames_a.delete(0);
					batch.insert(batch.size(),
						make_event(tsp_pkg::EV_LONE_A, head_a.tag, '0, head_a.stamp));
				end else if (frames_a.size() == 0 && frames_b.size() != 0) begin
					head_b = frames_b[0];
					frames_b.delete(0);
					batch.insert(batch.size(),
						make_event(tsp_pkg::EV_LONE_B, '0, head_b.tag, head_b.stamp));
				end
			end
		end
		if (batch.size() > 0)
			batch[batch.size()-1].last = 1'b1;
		foreach (batch[i])
			pending_events.insert(pending_events.size(), batch[i]);
	endfunction

	// send one frame transaction
	task automatic push_frame(input logic src, input logic [tsp_pkg::STAMP_W-1:0] stamp,
			input logic [tsp_pkg::TAG_IO_W-1:0] tag);
		while (idle_en && $urandom_range(99) < STALL_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= src;
		s_tdata  <= {tag, stamp};
		pair_arrival(src, stamp, tag);
		do @(posedge clk); while (!s_tready);
	endtask

	// hold the sender until every event is out and the block has gone quiet
	task automatic drain_block();
		s_tvalid <= 1'b0;
		while (pending_events.size() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	// register write while the block is idle
	task automatic write_reg(input logic [tsp_pkg::CFG_IDX_W-1:0] idx,
			input logic [tsp_pkg::WINDOW_W-1:0] data);
		drain_block();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == tsp_pkg::REG_MATCH_WINDOW)
			window_reg = data;
		else if (idx == tsp_pkg::REG_MIN_FILL)
			fill_reg = data[tsp_pkg::FILL_W-1:0];
	endtask

	// min_fill write with junk in the unused upper bits
	task automatic write_fill(input int fill);
		write_reg(tsp_pkg::REG_MIN_FILL,
			($urandom & ~32'h1F) | 32'(fill[tsp_pkg::FILL_W-1:0]));
	endtask

	// sensor streams with jitter, missed frames and some noise
	task automatic run_stream(input int n_items, input int jitter_max);
		int   sent;
		int   pick;
		logic first;
		sent = 0;
		while (sent < n_items) begin
			pick = $urandom_range(99);
			if (pick < 5) begin
				push_frame(1'($urandom_range(1)), {$urandom, $urandom}, 16'($urandom));
				sent++;
			end else if (pick < 15) begin
				push_frame(1'($urandom_range(1)),
					stream_ns + 64'($urandom_range(4 * jitter_max)), 16'($urandom));
				sent++;
			end else begin
				stream_ns += 64'(1000 + $urandom_range(400));
				if (pick < 25) begin
					push_frame(1'($urandom_range(1)),
						stream_ns + 64'($urandom_range(jitter_max)), 16'($urandom));
					sent++;
				end else begin
					first = 1'($urandom_range(1));
					push_frame(first, stream_ns + 64'($urandom_range(jitter_max)),
						16'($urandom));
					push_frame(!first, stream_ns + 64'($urandom_range(jitter_max)),
						16'($urandom));
					sent += 2;
				end
			end
		end
	endtask

	// window edges, extremes, equal stamps and lone heads
	task automatic test_directed();
		// reset values of the registers: window 500, min_fill 2
		push_frame(tsp_pkg::SRC_A, 64'd1000, 16'h0001);
		push_frame(tsp_pkg::SRC_B, 64'd1100, 16'h0101);
		push_frame(tsp_pkg::SRC_A, 64'd2000, 16'h0002);
		push_frame(tsp_pkg::SRC_B, 64'd2500, 16'h0102);
		push_frame(tsp_pkg::SRC_A, 64'd3000, 16'h0003);
		push_frame(tsp_pkg::SRC_B, 64'd3499, 16'h0103);
		// extreme stamps and tags
		push_frame(tsp_pkg::SRC_A, 64'd0, 16'h0000);
		push_frame(tsp_pkg::SRC_B, '1, 16'hFFFF);
		push_frame(tsp_pkg::SRC_A, '1, 16'hFFFF);
		push_frame(tsp_pkg::SRC_B, 64'd0, 16'h0000);
		push_frame(tsp_pkg::SRC_A, 64'hFFFF_FFFF_FFFF_FE10, 16'h8000);
		push_frame(tsp_pkg::SRC_B, 64'hFFFF_FFFF_FFFF_FFF0, 16'h7FFF);
		// zero window: equal stamps drop the B head, then lone heads
		write_reg(tsp_pkg::REG_MATCH_WINDOW, 32'd0);
		write_fill(0);
		push_frame(tsp_pkg::SRC_A, 64'd500, 16'h0A01);
		push_frame(tsp_pkg::SRC_B, 64'd500, 16'h0B01);
		push_frame(tsp_pkg::SRC_B, 64'd900, 16'h0B02);
		push_frame(tsp_pkg::SRC_A, 64'd950, 16'h0A02);
		push_frame(tsp_pkg::SRC_A, 64'd1300, 16'h0A03);
		push_frame(tsp_pkg::SRC_B, 64'd1400, 16'h0B03);
		// widest window, then writes to spare indexes must change nothing
		write_reg(tsp_pkg::REG_MATCH_WINDOW, '1);
		write_reg(REG_SPARE_2, 32'd0);
		write_reg(REG_SPARE_3, 32'h0000_001F);
		// widest window, just inside and just outside
		push_frame(tsp_pkg::SRC_A, 64'd0, 16'h0A04);
		push_frame(tsp_pkg::SRC_B, 64'h0000_0000_FFFF_FFFE, 16'h0B04);
		push_frame(tsp_pkg::SRC_A, 64'd0, 16'h0A05);
		push_frame(tsp_pkg::SRC_B, 64'h0000_0000_FFFF_FFFF, 16'h0B05);
	endtask

	// one fifo filled past its depth, then the other
	task automatic test_overflow();
		write_reg(tsp_pkg::REG_MATCH_WINDOW, 32'd500);
		write_fill(31);
		for (int i = 0; i < FIFO_DEPTH + 2; i++)
			push_frame(tsp_pkg::SRC_A, stream_ns + 64'(1000 * i), 16'($urandom));
		for (int i = 0; i < FIFO_DEPTH; i++)
			push_frame(tsp_pkg::SRC_B, stream_ns + 64'(1000 * i + 2100), 16'($urandom));
		stream_ns += 64'(1000 * (FIFO_DEPTH + 4));
		for (int i = 0; i < FIFO_DEPTH + 1; i++)
			push_frame(tsp_pkg::SRC_B, stream_ns + 64'(1000 * i), 16'($urandom));
		stream_ns += 64'(1000 * (FIFO_DEPTH + 2));
	endtask

	// deep drains: one long flush, then a drain cut by the result cap
	task automatic test_result_budget();
		write_fill(0);
		push_frame(tsp_pkg::SRC_A, 64'hF000_0000_0000_0000, 16'hABCD);
		write_fill(31);
		for (int i = 0; i < FIFO_DEPTH; i++)
			push_frame(tsp_pkg::SRC_A, stream_ns + 64'(2000 * i), 16'($urandom));
		for (int i = 0; i < FIFO_DEPTH; i++)
			push_frame(tsp_pkg::SRC_B, stream_ns + 64'(2000 * i + 1000), 16'($urandom));
		stream_ns += 64'(2000 * (FIFO_DEPTH + 1));
	endtask

	// random streams under several register settings
	task automatic test_random();
		// a stretch with no idling on either side
		idle_en  = 1'b0;
		stall_en = 1'b0;
		write_reg(tsp_pkg::REG_MATCH_WINDOW, 32'd500);
		write_fill(2);
		run_stream(60, 700);
		idle_en  = 1'b1;
		stall_en = 1'b1;
		write_reg(tsp_pkg::REG_MATCH_WINDOW, 32'd0);
		write_fill(0);
		run_stream(30, 700);
		write_reg(tsp_pkg::REG_MATCH_WINDOW, '1);
		write_fill(1);
		run_stream(30, 700);
		write_reg(tsp_pkg::REG_MATCH_WINDOW, $urandom_range(3000, 100));
		write_fill($urandom_range(7));
		run_stream(50, 2000);
		write_reg(tsp_pkg::REG_MATCH_WINDOW, 32'd1000);
		write_fill(31);
		run_stream(54, 1200);
	endtask

	// receiver back-pressure
	always @(posedge clk)
		m_tready <= arst_n && (!stall_en || $urandom_range(99) >= STALL_PCT);

	// result checker
	always @(posedge clk) begin : check_results
		sync_event_t exp_ev;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_events.size() == 0) begin
				$error("unexpected result: kind %0d, stamp %h", m_tuser, m_tdata[95:32]);
				err_count++;
			end else begin
				exp_ev = pending_events.pop_front();
				if (m_tuser !== exp_ev.kind) begin
					$error("event_kind mismatch: expected %0d, actual %0d", exp_ev.kind, m_tuser);
					err_count++;
				end
				if (m_tdata[15:0] !== exp_ev.tag_a) begin
					$error("tag_a mismatch: expected %h, actual %h", exp_ev.tag_a, m_tdata[15:0]);
					err_count++;
				end
				if (m_tdata[31:16] !== exp_ev.tag_b) begin
					$error("tag_b mismatch: expected %h, actual %h", exp_ev.tag_b, m_tdata[31:16]);
					err_count++;
				end
				if (m_tdata[95:32] !== exp_ev.stamp) begin
					$error("out_stamp mismatch: expected %h, actual %h", exp_ev.stamp,
						m_tdata[95:32]);
					err_count++;
				end
				if (m_tlast !== exp_ev.last) begin
					$error("last mismatch: expected %b, actual %b", exp_ev.last, m_tlast);
					err_count++;
				end
			end
		end
	end

	// watchdog on cycles with no transaction anywhere
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready))
			hang_cycles = 0;
		else
			hang_cycles++;
		if (hang_cycles >= HANG_LIMIT) begin
			$display("tb_top: done, errors");
			$finish;
		end
	end

	// test sequence
	initial begin
		clk         = 1'b0;
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tuser     = tsp_pkg::SRC_A;
		m_tready    = 1'b0;
		cfg_valid   = 1'b0;
		cfg_index   = tsp_pkg::REG_MATCH_WINDOW;
		cfg_data    = '0;
		idle_en     = 1'b1;
		stall_en    = 1'b1;
		err_count   = 0;
		hang_cycles = 0;
		window_reg  = tsp_pkg::WINDOW_RST;
		fill_reg    = tsp_pkg::FILL_RST;
		stream_ns   = 64'd100_000;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_overflow();
		test_result_budget();
		test_random();
		drain_block();
		repeat (20) @(posedge clk);
		if (err_count == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule
